/* rtl/core/longest_band_limited_run_defines.svh */
// Assertion macros used by the checker file.
`ifndef LONGEST_BAND_LIMITED_RUN_DEFINES_SVH
`define LONGEST_BAND_LIMITED_RUN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBLR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lblr_pkg.sv */
package lblr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LIMIT_W     = 16;
    localparam int OUT_LEN_W   = 9;
    localparam int SCAN_LANES  = 16;
    localparam int SCAN_LANE_W = 4;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register index is paddr[2]
    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } lblr_state_t;

    // Per-cell strobes from the sequencer
    typedef struct packed {
        logic shift;
        logic capture;
    } cell_ctrl_t;

    // Outcome of searching one group of conflict flags
    typedef struct packed {
        logic hit;
        logic last;
    } scan_flags_t;

endpackage

/* rtl/core/lblr_cell.sv */
module lblr_cell import lblr_pkg::*; (
    input  logic                       aclk,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] shift_in,
    input  logic signed [SAMPLE_W-1:0] probe,
    input  logic        [LIMIT_W-1:0]  limit,
    output logic signed [SAMPLE_W-1:0] sample_q,
    output logic                       conflict_q
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       conflict_reg;
    logic signed [SAMPLE_W:0]   diff;
    logic        [SAMPLE_W:0]   mag;

    assign diff = {sample_reg[SAMPLE_W-1], sample_reg} - {probe[SAMPLE_W-1], probe};
    assign mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

    always_ff @(posedge aclk) begin
        // advance the stored sample toward the older neighbor
        if (ctrl.shift) begin
            sample_reg <= shift_in;
        end
        if (ctrl.capture) begin
            conflict_reg <= (mag > {1'b0, limit});
        end
    end

    assign sample_q   = sample_reg;
    assign conflict_q = conflict_reg;

endmodule

/* rtl/core/lblr_scan.sv */
module lblr_scan import lblr_pkg::*; #(
    parameter int IDX_W = 12,
    parameter int LEN_W = 9
) (
    input  logic [SCAN_LANES-1:0] lanes,
    input  logic [IDX_W-1:0]      base,
    input  logic [LEN_W-1:0]      win_len,
    output logic [IDX_W-1:0]      hit_idx,
    output scan_flags_t           flags
);

    localparam int CMP_W = IDX_W + LEN_W + 1;

    logic [SCAN_LANES-1:0]  masked;
    logic [SCAN_LANE_W-1:0] pick;

    always_comb begin
        for (int l = 0; l < SCAN_LANES; l++) begin
            masked[l] = lanes[l]
                && (CMP_W'(base) + CMP_W'(l) < CMP_W'(win_len));
        end
    end

    // newest conflicting cell wins: lowest lane
    always_comb begin
        pick = '0;
        for (int l = SCAN_LANES - 1; l >= 0; l--) begin
            if (masked[l]) begin
                pick = SCAN_LANE_W'(l);
            end
        end
    end

    assign hit_idx    = {base[IDX_W-1:SCAN_LANE_W], pick};
    assign flags.hit  = |masked;
    assign flags.last = (CMP_W'(base) + CMP_W'(SCAN_LANES) >= CMP_W'(win_len));

endmodule

/* rtl/core/longest_band_limited_run.sv */
// Longest band-limited run. Each request carries one signed 16-bit sample and a
// restart flag; each produces exactly one result: the length of the longest
// window ending at that sample in which no two samples differ by more than the
// limit register, the longest such length since the last restart, and a sticky
// flag that is set once the window has been cut at WINDOW_DEPTH samples.
// The window lives in a row of WINDOW_DEPTH cells; cell k holds the sample k
// places back. On accepting a request every cell compares its sample with the
// new one in parallel and stores a conflict bit. A search unit then walks the
// conflict bits in groups of 16, newest first, and stops at the first group
// holding a conflict inside the window or at the group that reaches the window
// end. The number of groups walked is 1 to ceil(WINDOW_DEPTH/16), 16 at the
// default depth; the search holds its last group while the previous result
// is still waiting at the output. The next request is taken in the cycle
// after the result is loaded. The limit register sits at byte address 0; the
// user must write it only while the block is idle; the block does not enforce it.
module longest_band_limited_run import lblr_pkg::*; #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [15:0] sample
    input  logic [0:0]         s_tuser,   // [0] restart
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // [8:0] window_length, [17:9] best_length
    output logic [0:0]         m_tuser,   // [0] truncated
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int GROUPS = (WINDOW_DEPTH + SCAN_LANES - 1) / SCAN_LANES;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int IDX_W  = GRP_W + SCAN_LANE_W;
    localparam int PAD_W  = GROUPS * SCAN_LANES;

    lblr_state_t                state_reg, state_next;
    logic        [LIMIT_W-1:0]  limit_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic        [LEN_W-1:0]    len_reg, len_next;
    logic        [LEN_W-1:0]    best_reg, best_next;
    logic                       cut_reg, cut_next;
    logic        [GRP_W-1:0]    grp_reg, grp_next;
    logic                       m_tvalid_reg;
    logic        [23:0]         m_tdata_reg;
    logic                       m_tuser_reg;

    logic                       accept;
    logic                       out_free;
    logic                       finish;
    logic                       done;
    logic [LEN_W-1:0]           new_len;
    logic                       cut_now;
    cell_ctrl_t                 cell_ctrl;

    logic signed [SAMPLE_W-1:0] cell_sample [WINDOW_DEPTH];
    logic [PAD_W-1:0]           conflict_pad;
    logic [IDX_W-1:0]           base;
    logic [IDX_W-1:0]           hit_idx;
    scan_flags_t                flags;

    // ---------------------------------------------------------------- handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign done     = flags.hit || flags.last;
    assign finish   = (state_reg == ST_SCAN) && done && out_free;

    assign cell_ctrl.shift   = finish;
    assign cell_ctrl.capture = accept;

    // ---------------------------------------------------------------- cell row
    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        logic signed [SAMPLE_W-1:0] feed;
        if (k == 0) begin : g_head
            assign feed = sample_reg;
        end else begin : g_body
            assign feed = cell_sample[k-1];
        end
        lblr_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .shift_in   (feed),
            .probe      (s_tdata),
            .limit      (limit_reg),
            .sample_q   (cell_sample[k]),
            .conflict_q (conflict_pad[k])
        );
    end

    if (PAD_W > WINDOW_DEPTH) begin : g_pad
        assign conflict_pad[PAD_W-1:WINDOW_DEPTH] = '0;
    end

    // ---------------------------------------------------------------- group search
    assign base = {grp_reg, {SCAN_LANE_W{1'b0}}};

    lblr_scan #(
        .IDX_W (IDX_W),
        .LEN_W (LEN_W)
    ) u_scan (
        .lanes   (conflict_pad[base +: SCAN_LANES]),
        .base    (base),
        .win_len (len_reg),
        .hit_idx (hit_idx),
        .flags   (flags)
    );

    // A conflict at cell k keeps the k newer cells plus the new sample.
    // With no conflict the window grows, or drops its oldest sample when full.
    always_comb begin
        cut_now = 1'b0;
        if (flags.hit) begin
            new_len = LEN_W'(hit_idx) + 1'b1;
        end else if (len_reg == LEN_W'(WINDOW_DEPTH)) begin
            new_len = len_reg;
            cut_now = 1'b1;
        end else begin
            new_len = len_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        best_next  = best_reg;
        cut_next   = cut_reg;
        grp_next   = grp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    grp_next   = '0;
                    state_next = ST_SCAN;
                    // restart: drop the window, best length and cut flag
                    if (s_tuser[0]) begin
                        len_next  = '0;
                        best_next = '0;
                        cut_next  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    len_next   = new_len;
                    best_next  = (new_len > best_reg) ? new_len : best_reg;
                    cut_next   = cut_reg || cut_now;
                    state_next = ST_IDLE;
                end else if (!done) begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            best_reg     <= '0;
            cut_reg      <= 1'b0;
            grp_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            best_reg  <= best_next;
            cut_reg   <= cut_next;
            grp_reg   <= grp_next;
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the new sample until it enters the head cell.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= {6'b0, OUT_LEN_W'(best_next), OUT_LEN_W'(new_len)};
            m_tuser_reg <= cut_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------------------------------------------------------- register port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(limit_reg) : '0;

endmodule

/* rtl/core/lblr_checker.sv */
`include "longest_band_limited_run_defines.svh"

module lblr_checker #(
    parameter int WINDOW_DEPTH = 256
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    localparam logic       EXACT    = (WINDOW_DEPTH < 512);
    localparam logic [8:0] FULL_LEN = 9'(WINDOW_DEPTH);

    logic        s_take;
    logic        m_stall;
    logic        m_show;
    logic        cut_show;
    logic        len_ok;
    logic [24:0] m_word;
    logic [8:0]  win_len;
    logic [8:0]  best_len;

    assign s_take   = s_tvalid && s_tready;
    assign m_stall  = m_tvalid && !m_tready;
    assign m_show   = EXACT && m_tvalid;
    assign cut_show = m_show && m_tuser[0];
    assign m_word   = {m_tuser, m_tdata};
    assign win_len  = m_tdata[8:0];
    assign best_len = m_tdata[17:9];
    assign len_ok   = (win_len != 9'd0) && (win_len <= best_len);

    // one request in flight: intake closes right after a request
    `LBLR_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_take, !s_tready, "request during scan")

    // a stalled result holds
    `LBLR_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_word), "result moved")

    // window is never empty and never longer than the best length
    `LBLR_ASSERT_NOW(a_len_order, aclk, aresetn, m_show, len_ok, "window length out of order")

    // a cut only happens once the window has filled the row
    `LBLR_ASSERT_NOW(a_cut_full, aclk, aresetn, cut_show, best_len == FULL_LEN, "cut before full")

endmodule

bind longest_band_limited_run lblr_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lblr_checker (.*);
